[rtl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/rgbpq_pkg.sv]
//------------------------------------------------------------------------------
// rgbpq_pkg
// Shared types and constants for the palette quantizer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rgbpq_pkg;
    localparam int unsigned STORE_DEPTH = 256;
    localparam logic [7:0]  ALPHA_RESET = 8'd127;
    localparam logic [15:0] NEW_FLAG    = 16'h8000;

    // classified item passed from front to back
    typedef struct packed {
        logic        opaque;
        logic        start;
        logic [23:0] key;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  color_index;
        logic        new_entry_valid;
        logic [15:0] new_entry_color;
        logic [8:0]  palette_count;
    } t_res;

    function automatic logic [14:0] to_rgb555(input logic [23:0] key);
        to_rgb555 = {key[7:3], key[15:11], key[23:19]};
    endfunction
endpackage
`default_nettype wire

[rtl/rgbpq_front.sv]
//------------------------------------------------------------------------------
// rgbpq_front
// Accepts pixels, applies padding and alpha test, queues commands.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rgbpq_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    output wire                 o_cfg_ready,
    input  wire [7:0]           i_cfg_data,
    input  wire                 i_valid,
    output wire                 o_ready,
    input  wire [31:0]          i_data,
    input  wire [1:0]           i_user,
    output wire                 o_cmd_valid,
    input  wire                 i_cmd_ready,
    output rgbpq_pkg::t_cmd     o_cmd
);
    import rgbpq_pkg::*;

    logic [7:0] r_thr;
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_in;
    logic       w_push, w_pop;

    assign o_cfg_ready = i_rst_n;
    assign o_ready     = i_rst_n && (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        w_in.opaque = !i_user[0] && (i_data[31:24] > r_thr);
        w_in.start  = i_user[1];
        w_in.key    = {i_data[7:0], i_data[15:8], i_data[23:16]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ALPHA_RESET;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_cfg_valid) r_thr <= i_cfg_data;
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_in;
    end
endmodule
`default_nettype wire

[rtl/rgbpq_back.sv]
//------------------------------------------------------------------------------
// rgbpq_back
// Scans palette memory for exact key, appends, or finds nearest color; transparent items skip the scan.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rgbpq_back #(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cmd_valid,
    output wire                 o_cmd_ready,
    input  rgbpq_pkg::t_cmd     i_cmd,
    output wire                 o_valid,
    input  wire                 i_ready,
    output rgbpq_pkg::t_res     o_res
);
    import rgbpq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXACT = 3'd1;
    localparam logic [2:0] S_NEAR  = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;
    localparam logic [8:0] LIMIT   = 9'(PALETTE_ENTRIES);

    logic [2:0]  r_st;
    logic [8:0]  r_cnt;
    logic [8:0]  r_i;
    logic        r_rdv;
    logic [7:0]  r_ri;
    logic [23:0] r_key;
    logic [23:0] r_kd;
    logic [14:0] r_cd;
    logic [23:0] r_keys [STORE_DEPTH];
    logic [14:0] r_cols [STORE_DEPTH];
    logic [7:0]  r_best;
    logic [17:0] r_bd;
    logic        r_bv;
    logic        r_ov;
    t_res        r_res;
    logic        w_ld;
    logic [8:0]  w_cnt;
    logic signed [5:0] w_dr, w_dg, w_db;
    logic signed [11:0] w_sr, w_sg, w_sb;
    logic [17:0] w_d;
    logic [14:0] w_c15;

    assign o_cmd_ready = (r_st == S_IDLE) && !r_ov;
    assign w_ld  = i_cmd_valid && o_cmd_ready;
    assign o_valid = r_ov;
    assign o_res = r_res;
    assign w_cnt = i_cmd.start ? 9'd1 : r_cnt;
    assign w_c15 = to_rgb555(r_key);

    always_comb begin
        w_dr = 6'(signed'({1'b0, w_c15[4:0]}))   - 6'(signed'({1'b0, r_cd[4:0]}));
        w_dg = 6'(signed'({1'b0, w_c15[9:5]}))   - 6'(signed'({1'b0, r_cd[9:5]}));
        w_db = 6'(signed'({1'b0, w_c15[14:10]})) - 6'(signed'({1'b0, r_cd[14:10]}));
        w_sr = w_dr * w_dr;
        w_sg = w_dg * w_dg;
        w_sb = w_db * w_db;
        w_d  = 18'(unsigned'(w_sr)) * 18'd2 + 18'(unsigned'(w_sg)) * 18'd4
             + 18'(unsigned'(w_sb)) * 18'd3;
    end

    always_ff @(posedge i_clk) begin
        r_kd <= r_keys[r_i[7:0]];
        r_cd <= r_cols[r_i[7:0]];
        if (r_st == S_DONE && r_cnt < LIMIT && r_bv) begin
            r_keys[r_cnt[7:0]] <= r_key;
            r_cols[r_cnt[7:0]] <= w_c15;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_cnt <= 9'd1;
            r_ov  <= 1'b0;
            r_rdv <= 1'b0;
            r_bv  <= 1'b0;
        end else begin
            if (o_valid && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (w_ld) begin
                        r_cnt <= w_cnt;
                        r_key <= i_cmd.key;
                        r_i   <= 9'd1;
                        r_rdv <= 1'b0;
                        r_bv  <= 1'b0;
                        r_bd  <= '1;
                        r_best <= 8'd1;
                        if (i_cmd.opaque) r_st <= S_EXACT;
                        else begin
                            r_res <= '{8'd0, 1'b0, 16'd0, w_cnt};
                            r_ov  <= 1'b1;
                        end
                    end
                end
                S_EXACT: begin
                    r_rdv <= (r_i < r_cnt);
                    r_ri  <= r_i[7:0];
                    if (r_i < r_cnt) r_i <= r_i + 9'd1;
                    if (r_rdv && r_kd == r_key) begin
                        r_res <= '{r_ri, 1'b0, 16'd0, r_cnt};
                        r_ov  <= 1'b1;
                        r_st  <= S_IDLE;
                    end else if (!r_rdv && r_i >= r_cnt) begin
                        r_i   <= 9'd1;
                        if (r_cnt < LIMIT) begin
                            r_bv <= 1'b1;
                            r_st <= S_DONE;
                        end else r_st <= S_NEAR;
                    end
                end
                S_NEAR: begin
                    r_rdv <= (r_i < r_cnt);
                    r_ri  <= r_i[7:0];
                    if (r_i < r_cnt) r_i <= r_i + 9'd1;
                    if (r_rdv && w_d < r_bd) begin
                        r_bd   <= w_d;
                        r_best <= r_ri;
                    end
                    if (!r_rdv && r_i >= r_cnt) r_st <= S_DONE;
                end
                S_DONE: begin
                    if (r_bv) begin
                        r_res <= '{r_cnt[7:0], 1'b1, NEW_FLAG | {1'b0, w_c15},
                                   r_cnt + 9'd1};
                        r_cnt <= r_cnt + 9'd1;
                    end else r_res <= '{r_best, 1'b0, 16'd0, r_cnt};
                    r_bv <= 1'b0;
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/rgb_to_palette_index_quantizer.sv]
//------------------------------------------------------------------------------
// rgb_to_palette_index_quantizer
// RGBA pixel to palette index with exact match, append, nearest color.
//------------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                         tuser
// s_axis   in   red, green, blue, alpha                    outside_image, start_of_image
// m_axis   out  color_index, new_entry_valid,              -
//               new_entry_color, palette_count, pad
// cfg      in   alpha_threshold                            -
// With the back end idle, a transparent item gives its result without a scan;
// opaque ones scan the palette memory one entry per cycle: an exact hit stops
// the scan at its index, an append follows a full exact pass, and a full
// palette takes an exact pass and then a nearest-color pass.
// Reset is synchronous; the palette needs no clearing pass.
// A two-entry queue lets input run ahead while a result stalls.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_palette_index_quantizer #(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    output wire        o_cfg_ready,
    input  wire [7:0]  i_cfg_data,      // alpha_threshold
    input  wire        s_axis_tvalid,
    output wire        s_axis_tready,
    input  wire [31:0] s_axis_tdata,    // red, green, blue, alpha
    input  wire [1:0]  s_axis_tuser,    // outside_image, start_of_image
    output wire        m_axis_tvalid,
    input  wire        m_axis_tready,
    output wire [39:0] m_axis_tdata     // index, new valid, new color, count
);
    import rgbpq_pkg::*;

    t_cmd w_cmd;
    t_res w_res;
    logic w_cv, w_cr;

    rgbpq_front u_front (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata), .i_user(s_axis_tuser),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    rgbpq_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.palette_count, w_res.new_entry_color,
                           w_res.new_entry_valid, w_res.color_index};
endmodule
`default_nettype wire

[rtl/rgbpq_checker.sv]
//------------------------------------------------------------------------------
// rgbpq_checker
// Port-level checks on the quantizer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rgbpq_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata
);
    `ASSERT_IMPL(a_new_flag, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[8], m_axis_tdata[24])
    `ASSERT_IMPL(a_no_color, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[8], m_axis_tdata[24:9] == 16'd0)
    `ASSERT_IMPL(a_cnt_min, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[33:25] != 9'd0)
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
endmodule
bind rgb_to_palette_index_quantizer rgbpq_checker u_chk (.*);
`default_nettype wire
